/* rtl/srdc_pkg.sv */
// Shared constants, register codes and saturation helpers for the stereo resampler.
package srdc_pkg;

	// Field widths.
	localparam int SAMPLE_W = 18;
	localparam int OUT_W    = 16;
	localparam int ACC_W    = 24;
	localparam int STEP_W   = 19;
	localparam int GAIN_W   = 16;
	localparam int COEF_W   = 17;
	localparam int REM_W    = 17;
	localparam int FRAC_W   = 16;
	localparam int DIFF_W   = 26;
	localparam int WIDE_W   = 43;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HP_COEF      = 2'd3;

	// Register values after reset.
	localparam logic [STEP_W-1:0] RATE_STEP_RST    = 19'd58134;
	localparam logic [STEP_W-1:0] INVERSE_STEP_RST = 19'd73881;
	localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST  = 16'd4096;
	localparam logic [COEF_W-1:0] HP_COEF_RST      = 17'd65489;

	// One in Q16, as a position and as a remainder.
	localparam logic [STEP_W-1:0] ONE_Q16     = 19'd65536;
	localparam logic [REM_W-1:0]  ONE_Q16_REM = 17'd65536;

	// Repeat count: the integer part of the position is three bits wide.
	localparam int REP_W = 3;
	localparam logic [REP_W-1:0] MAX_REPEATS = 3'd4;

	// Shared bit-serial multiplier: signed A times unsigned B.
	localparam int MUL_A_W   = 40;
	localparam int MUL_B_W   = 19;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = 5;
	localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 5'(MUL_B_W);

	// Saturation bounds.
	localparam int S24_MAX = 8388607;
	localparam int S24_MIN = -8388608;
	localparam int S16_MAX = 32767;
	localparam int S16_MIN = -32768;

	// Saturate a wide signed value to 24 bits.
	function automatic logic signed [ACC_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > S24_MAX) begin
			r = 24'sh7FFFFF;
		end else if (v < S24_MIN) begin
			r = 24'sh800000;
		end else begin
			r = ACC_W'(v);
		end
		return r;
	endfunction

	// Saturate a 24-bit signed value to the 16-bit output range.
	function automatic logic signed [OUT_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > S16_MAX) begin
			r = 16'sh7FFF;
		end else if (v < S16_MIN) begin
			r = 16'sh8000;
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

endpackage

/* rtl/stereo_resampler_dc_block.sv */
// Stereo box-filter resampler with output gain and a DC-blocking highpass.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    sample_left, sample_right
//   out      out        out_valid / out_ready  out_left, out_right, last_of_run
//
// All products go through one shared multiplier that takes one bit of its
// unsigned operand per cycle. A split crossing input first computes the remainder
// and the carried part of each channel. An input that yields outputs scales each
// channel by gain and step, then runs the highpass on both channels per output
// unless it is bypassed. Reset returns the configuration registers, control state,
// accumulators and highpass state to their defaults; the next input is
// taken while the last output still waits in the output register.
module stereo_resampler_dc_block (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [srdc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [srdc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [srdc_pkg::SAMPLE_W-1:0]   sample_left,
	input  logic signed [srdc_pkg::SAMPLE_W-1:0]   sample_right,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [srdc_pkg::OUT_W-1:0]      out_left,
	output logic signed [srdc_pkg::OUT_W-1:0]      out_right,
	output logic                                   last_of_run
);

	// Sequencer states.
	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
	localparam logic [STATE_W-1:0] S_REM   = 3'd1;
	localparam logic [STATE_W-1:0] S_CARRY = 3'd2;
	localparam logic [STATE_W-1:0] S_GAIN  = 3'd3;
	localparam logic [STATE_W-1:0] S_SCALE = 3'd4;
	localparam logic [STATE_W-1:0] S_FILT  = 3'd5;
	localparam logic [STATE_W-1:0] S_EMIT  = 3'd6;

	// Configuration registers.
	logic [srdc_pkg::STEP_W-1:0] rate_step_q;
	logic [srdc_pkg::STEP_W-1:0] inverse_step_q;
	logic [srdc_pkg::GAIN_W-1:0] output_gain_q;
	logic [srdc_pkg::COEF_W-1:0] hp_coef_q;

	// Block state.
	logic [STATE_W-1:0]                   state_q, state_d;
	logic                                 ch_q;
	logic [srdc_pkg::REP_W-1:0]           k_q;
	logic [srdc_pkg::REP_W-1:0]           reps_q;
	logic [srdc_pkg::STEP_W-1:0]          position_q;
	logic signed [srdc_pkg::ACC_W-1:0]    acc_q [2];
	logic signed [srdc_pkg::SAMPLE_W-1:0] carry_q [2];
	logic signed [srdc_pkg::ACC_W-1:0]    held_q [2];
	logic signed [srdc_pkg::ACC_W-1:0]    prev_in_q [2];
	logic signed [srdc_pkg::ACC_W-1:0]    prev_out_q [2];
	logic signed [srdc_pkg::ACC_W-1:0]    y_q [2];
	logic signed [srdc_pkg::SAMPLE_W-1:0] smp_q [2];
	logic [srdc_pkg::REM_W-1:0]           rem_q;

	// Output register.
	logic                                 out_valid_q;
	logic signed [srdc_pkg::OUT_W-1:0]    out_left_q;
	logic signed [srdc_pkg::OUT_W-1:0]    out_right_q;
	logic                                 last_q;

	// Multiplier registers and launch controls.
	logic signed [srdc_pkg::MUL_A_W-1:0]  mul_a_q;
	logic [srdc_pkg::MUL_P_W-1:0]         mul_p_q;
	logic [srdc_pkg::MUL_CNT_W-1:0]       mul_cnt_q;
	logic                                 mul_ld;
	logic signed [srdc_pkg::MUL_A_W-1:0]  mul_ld_a;
	logic [srdc_pkg::MUL_B_W-1:0]         mul_ld_b;
	logic                                 mul_done;
	logic signed [srdc_pkg::MUL_A_W-1:0]  mul_hi;
	logic signed [srdc_pkg::MUL_A_W:0]    mul_sum;

	// Datapath terms.
	logic                                 in_fire;
	logic                                 cfg_fire;
	logic                                 out_load;
	logic                                 emit_last;
	logic                                 bypass;
	logic [srdc_pkg::STEP_W:0]            pos_sum;
	logic [srdc_pkg::STEP_W-1:0]          pos_sat;
	logic                                 pos_hit;
	logic                                 split;
	logic [srdc_pkg::REP_W-1:0]           reps_new;
	logic [srdc_pkg::COEF_W-1:0]          step_min;
	logic signed [srdc_pkg::SAMPLE_W-1:0] smp_in [2];
	logic signed [srdc_pkg::ACC_W-1:0]    acc_add [2];
	logic signed [srdc_pkg::DIFF_W-1:0]   filt_d [2];
	logic signed [srdc_pkg::ACC_W-1:0]    emit_y [2];
	logic [srdc_pkg::STEP_W-1:0]          rem_raw;
	logic [srdc_pkg::REM_W-1:0]           rem_new;
	logic signed [srdc_pkg::SAMPLE_W-1:0] carry_new;
	logic signed [srdc_pkg::ACC_W-1:0]    acc_split;
	logic signed [srdc_pkg::MUL_A_W-1:0]  gain_p;
	logic signed [30:0]                   scale_p;
	logic signed [srdc_pkg::WIDE_W-1:0]   filt_p;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign emit_last = ((k_q + srdc_pkg::REP_W'(1)) == reps_q);

	assign out_valid   = out_valid_q;
	assign out_left    = out_left_q;
	assign out_right   = out_right_q;
	assign last_of_run = last_q;

	// Position advance, split decision and repeat count.
	assign pos_sum  = {1'b0, position_q} + {1'b0, rate_step_q};
	assign pos_sat  = pos_sum[srdc_pkg::STEP_W] ? '1 : pos_sum[srdc_pkg::STEP_W-1:0];
	assign pos_hit  = (pos_sat >= srdc_pkg::ONE_Q16);
	assign split    = (pos_sat > srdc_pkg::ONE_Q16) && (rate_step_q <= srdc_pkg::ONE_Q16);
	assign reps_new = (pos_sat[18:16] > srdc_pkg::MAX_REPEATS) ? srdc_pkg::MAX_REPEATS
		: pos_sat[18:16];
	assign step_min = (rate_step_q < srdc_pkg::ONE_Q16) ? rate_step_q[srdc_pkg::COEF_W-1:0]
		: srdc_pkg::ONE_Q16_REM;
	assign bypass   = hp_coef_q[srdc_pkg::COEF_W-1];

	assign smp_in[0] = sample_left;
	assign smp_in[1] = sample_right;

	// Per-channel sums: plain accumulation, filter difference, emitted value.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			acc_add[c] = srdc_pkg::sat24(srdc_pkg::WIDE_W'(acc_q[c])
				+ srdc_pkg::WIDE_W'(smp_in[c]));
			filt_d[c]  = srdc_pkg::DIFF_W'(prev_out_q[c]) + srdc_pkg::DIFF_W'(held_q[c])
				- srdc_pkg::DIFF_W'(prev_in_q[c]);
			emit_y[c]  = bypass ? held_q[c] : y_q[c];
		end
	end

	// Views of the finished product for each use.
	assign rem_raw   = mul_p_q[34:16];
	assign rem_new   = (rem_raw > srdc_pkg::ONE_Q16) ? srdc_pkg::ONE_Q16_REM
		: rem_raw[srdc_pkg::REM_W-1:0];
	assign carry_new = mul_p_q[33:16];
	assign acc_split = srdc_pkg::sat24(srdc_pkg::WIDE_W'(acc_q[ch_q])
		+ srdc_pkg::WIDE_W'(smp_q[ch_q]) - srdc_pkg::WIDE_W'(carry_new));
	assign gain_p    = mul_p_q[srdc_pkg::MUL_A_W-1:0];
	assign scale_p   = mul_p_q[58:28];
	assign filt_p    = mul_p_q[58:16];

	// One multiplier step: add A when the low bit is set, then shift right.
	assign mul_done = (mul_cnt_q == '0);
	assign mul_hi   = mul_p_q[srdc_pkg::MUL_P_W-1:srdc_pkg::MUL_B_W];
	assign mul_sum  = {mul_hi[srdc_pkg::MUL_A_W-1], mul_hi}
		+ (mul_p_q[0] ? {mul_a_q[srdc_pkg::MUL_A_W-1], mul_a_q} : '0);

	// Sequencer: next state and multiplier launches.
	always_comb begin
		state_d  = state_q;
		mul_ld   = 1'b0;
		mul_ld_a = '0;
		mul_ld_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (split) begin
						state_d  = S_REM;
						mul_ld   = 1'b1;
						mul_ld_a = srdc_pkg::MUL_A_W'(pos_sat[srdc_pkg::FRAC_W-1:0]);
						mul_ld_b = inverse_step_q;
					end else if (pos_hit) begin
						state_d  = S_GAIN;
						mul_ld   = 1'b1;
						mul_ld_a = srdc_pkg::MUL_A_W'(acc_add[0]);
						mul_ld_b = srdc_pkg::MUL_B_W'(output_gain_q);
					end
				end
			end
			S_REM: begin
				if (mul_done) begin
					state_d  = S_CARRY;
					mul_ld   = 1'b1;
					mul_ld_a = srdc_pkg::MUL_A_W'(smp_q[0]);
					mul_ld_b = srdc_pkg::MUL_B_W'(rem_new);
				end
			end
			S_CARRY: begin
				if (mul_done) begin
					mul_ld = 1'b1;
					if (!ch_q) begin
						mul_ld_a = srdc_pkg::MUL_A_W'(smp_q[1]);
						mul_ld_b = srdc_pkg::MUL_B_W'(rem_q);
					end else begin
						state_d  = S_GAIN;
						mul_ld_a = srdc_pkg::MUL_A_W'(acc_q[0]);
						mul_ld_b = srdc_pkg::MUL_B_W'(output_gain_q);
					end
				end
			end
			S_GAIN: begin
				if (mul_done) begin
					state_d  = S_SCALE;
					mul_ld   = 1'b1;
					mul_ld_a = gain_p;
					mul_ld_b = srdc_pkg::MUL_B_W'(step_min);
				end
			end
			S_SCALE: begin
				if (mul_done) begin
					if (!ch_q) begin
						state_d  = S_GAIN;
						mul_ld   = 1'b1;
						mul_ld_a = srdc_pkg::MUL_A_W'(acc_q[1]);
						mul_ld_b = srdc_pkg::MUL_B_W'(output_gain_q);
					end else if (bypass) begin
						state_d = S_EMIT;
					end else begin
						state_d  = S_FILT;
						mul_ld   = 1'b1;
						mul_ld_a = srdc_pkg::MUL_A_W'(filt_d[0]);
						mul_ld_b = srdc_pkg::MUL_B_W'(hp_coef_q);
					end
				end
			end
			S_FILT: begin
				if (mul_done) begin
					if (!ch_q) begin
						mul_ld   = 1'b1;
						mul_ld_a = srdc_pkg::MUL_A_W'(filt_d[1]);
						mul_ld_b = srdc_pkg::MUL_B_W'(hp_coef_q);
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (out_load) begin
					if (emit_last) begin
						state_d = S_IDLE;
					end else if (!bypass) begin
						state_d  = S_FILT;
						mul_ld   = 1'b1;
						mul_ld_a = srdc_pkg::MUL_A_W'(filt_d[0]);
						mul_ld_b = srdc_pkg::MUL_B_W'(hp_coef_q);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_step_q    <= srdc_pkg::RATE_STEP_RST;
			inverse_step_q <= srdc_pkg::INVERSE_STEP_RST;
			output_gain_q  <= srdc_pkg::OUTPUT_GAIN_RST;
			hp_coef_q      <= srdc_pkg::HP_COEF_RST;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				srdc_pkg::CFG_RATE_STEP:    rate_step_q    <= cfg_data;
				srdc_pkg::CFG_INVERSE_STEP: inverse_step_q <= cfg_data;
				srdc_pkg::CFG_OUTPUT_GAIN:  output_gain_q  <= cfg_data[srdc_pkg::GAIN_W-1:0];
				srdc_pkg::CFG_HP_COEF:      hp_coef_q      <= cfg_data[srdc_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Control state, accumulators and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			k_q         <= '0;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			position_q  <= '0;
			for (int c = 0; c < 2; c++) begin
				acc_q[c]      <= '0;
				carry_q[c]    <= '0;
				held_q[c]     <= '0;
				prev_in_q[c]  <= '0;
				prev_out_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;

			// Step counter of the multiplier.
			if (mul_ld) begin
				mul_cnt_q <= srdc_pkg::MUL_STEPS;
			end else if (!mul_done) begin
				mul_cnt_q <= mul_cnt_q - srdc_pkg::MUL_CNT_W'(1);
			end

			// Channel toggles after each carry, scaling and highpass product.
			if (mul_done && (state_q == S_CARRY || state_q == S_SCALE || state_q == S_FILT)) begin
				ch_q <= ~ch_q;
			end

			// Accepted input: advance position, accumulate when not split.
			if (in_fire) begin
				position_q <= pos_hit ? srdc_pkg::STEP_W'(pos_sat[srdc_pkg::FRAC_W-1:0])
					: pos_sat;
				k_q <= '0;
				if (!split) begin
					for (int c = 0; c < 2; c++) begin
						acc_q[c]   <= acc_add[c];
						carry_q[c] <= '0;
					end
				end
			end

			// Split input: keep the carried part, accumulate the rest.
			if (state_q == S_CARRY && mul_done) begin
				carry_q[ch_q] <= carry_new;
				acc_q[ch_q]   <= acc_split;
			end

			// Scaled sum is held; the carried part starts the next sum.
			if (state_q == S_SCALE && mul_done) begin
				held_q[ch_q] <= srdc_pkg::sat24(srdc_pkg::WIDE_W'(scale_p));
				acc_q[ch_q]  <= srdc_pkg::SAMPLE_W'(0) + srdc_pkg::ACC_W'(carry_q[ch_q]);
			end

			// Highpass state update.
			if (state_q == S_FILT && mul_done) begin
				prev_in_q[ch_q]  <= held_q[ch_q];
				prev_out_q[ch_q] <= srdc_pkg::sat24(filt_p);
			end

			// Output register and repeat counter.
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!emit_last) begin
					k_q <= k_q + srdc_pkg::REP_W'(1);
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (mul_ld) begin
			mul_a_q <= mul_ld_a;
			mul_p_q <= {{srdc_pkg::MUL_A_W{1'b0}}, mul_ld_b};
		end else if (!mul_done) begin
			mul_p_q <= {mul_sum, mul_p_q[srdc_pkg::MUL_B_W-1:1]};
		end

		if (in_fire) begin
			smp_q[0] <= sample_left;
			smp_q[1] <= sample_right;
			reps_q   <= reps_new;
		end

		if (state_q == S_REM && mul_done) begin
			rem_q <= rem_new;
		end

		if (state_q == S_FILT && mul_done) begin
			y_q[ch_q] <= srdc_pkg::sat24(filt_p);
		end

		if (out_load) begin
			out_left_q  <= srdc_pkg::sat16(emit_y[0]);
			out_right_q <= srdc_pkg::sat16(emit_y[1]);
			last_q      <= emit_last;
		end
	end

endmodule
